// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the serial frame receiver modules.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam logic [7:0]  START_BYTE    = 8'h02;
    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_CHECKSUM,
        PH_TRAILER
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_FRAME_END = 2'd1,
        KIND_LEN_ERROR = 2'd2
    } t_kind;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic        checksum_ok;
        logic [15:0] frame_length;
    } t_result;

endpackage

// ===== rtl/sfr_parse.sv =====
// ----------------------------------------------------------------------------
// sfr_parse
// Frame state machine: start hunt, length, payload, checksum and trailer.
// ----------------------------------------------------------------------------
module sfr_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_byte,
    input  logic [15:0]      i_max_len,
    output sfr_pkg::t_result o_res
);

    sfr_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_declared_length, n_declared_length;
    logic [15:0] r_bytes_remaining, n_bytes_remaining;
    logic [7:0]  r_running_xor, n_running_xor;
    logic        r_checksum_match, n_checksum_match;

    logic [15:0] len_full;
    logic [15:0] remaining_dec;

    assign len_full      = {r_declared_length[15:8], i_byte};
    assign remaining_dec = (r_bytes_remaining != 16'd0) ? r_bytes_remaining - 16'd1
                                                        : r_bytes_remaining;

    always_comb begin
        n_phase           = r_phase;
        n_declared_length = r_declared_length;
        n_bytes_remaining = r_bytes_remaining;
        n_running_xor     = r_running_xor;
        n_checksum_match  = r_checksum_match;
        if (i_en) begin
            case (r_phase)
                sfr_pkg::PH_LEN_HI: begin
                    n_declared_length = {i_byte, 8'd0};
                    n_running_xor     = r_running_xor ^ i_byte;
                    n_phase           = sfr_pkg::PH_LEN_LO;
                end
                sfr_pkg::PH_LEN_LO: begin
                    n_declared_length = len_full;
                    n_running_xor     = r_running_xor ^ i_byte;
                    if (len_full > i_max_len) begin
                        n_phase = sfr_pkg::PH_HUNT;
                    end else begin
                        n_bytes_remaining = len_full;
                        n_phase = (len_full == 16'd0) ? sfr_pkg::PH_CHECKSUM
                                                      : sfr_pkg::PH_PAYLOAD;
                    end
                end
                sfr_pkg::PH_PAYLOAD: begin
                    n_running_xor     = r_running_xor ^ i_byte;
                    n_bytes_remaining = remaining_dec;
                    if (remaining_dec == 16'd0) begin
                        n_phase = sfr_pkg::PH_CHECKSUM;
                    end
                end
                sfr_pkg::PH_CHECKSUM: begin
                    n_checksum_match = (i_byte == r_running_xor);
                    n_phase          = sfr_pkg::PH_TRAILER;
                end
                sfr_pkg::PH_TRAILER: begin
                    n_phase = sfr_pkg::PH_HUNT;
                end
                default: begin
                    if (i_byte == sfr_pkg::START_BYTE) begin
                        n_running_xor     = 8'd0;
                        n_declared_length = 16'd0;
                        n_bytes_remaining = 16'd0;
                        n_checksum_match  = 1'b0;
                        n_phase           = sfr_pkg::PH_LEN_HI;
                    end else begin
                        n_phase = sfr_pkg::PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_res              = '0;
        o_res.kind         = sfr_pkg::KIND_PAYLOAD;
        if (i_en) begin
            case (r_phase)
                sfr_pkg::PH_LEN_LO: begin
                    if (len_full > i_max_len) begin
                        o_res.valid        = 1'b1;
                        o_res.kind         = sfr_pkg::KIND_LEN_ERROR;
                        o_res.frame_length = len_full;
                    end
                end
                sfr_pkg::PH_PAYLOAD: begin
                    o_res.valid        = 1'b1;
                    o_res.kind         = sfr_pkg::KIND_PAYLOAD;
                    o_res.payload_byte = i_byte;
                end
                sfr_pkg::PH_TRAILER: begin
                    o_res.valid        = 1'b1;
                    o_res.kind         = sfr_pkg::KIND_FRAME_END;
                    o_res.checksum_ok  = r_checksum_match;
                    o_res.frame_length = r_declared_length;
                end
                default: begin
                    o_res.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= sfr_pkg::PH_HUNT;
            r_declared_length <= 16'd0;
            r_bytes_remaining <= 16'd0;
            r_running_xor     <= 8'd0;
            r_checksum_match  <= 1'b0;
        end else begin
            r_phase           <= n_phase;
            r_declared_length <= n_declared_length;
            r_bytes_remaining <= n_bytes_remaining;
            r_running_xor     <= n_running_xor;
            r_checksum_match  <= n_checksum_match;
        end
    end

    a_payload_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == sfr_pkg::PH_PAYLOAD |-> r_bytes_remaining != 16'd0)
        else $error("payload phase with no bytes remaining");

    a_trailer_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_phase == sfr_pkg::PH_TRAILER |=> r_phase == sfr_pkg::PH_HUNT)
        else $error("trailer did not return to hunt");

    a_len_error_above_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.kind == sfr_pkg::KIND_LEN_ERROR
        |-> o_res.frame_length > i_max_len)
        else $error("length error with length within limit");

endmodule

// ===== rtl/serial_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// serial_frame_receiver_top
// STX / length / payload / XOR checksum / trailer frame receiver.
//
//   channel  dir  valid    stall    payload
//   input    in   i_valid  o_stall  i_rx_byte
//   result   out  o_valid  i_stall  o_result_kind, o_payload_byte,
//                                   o_checksum_ok, o_frame_length
//   config   in   i_cfg_wr_en  -    i_cfg_wr_data
//
// One byte per cycle sustained while the result side is not stalled; a result
// passes through the input register, then the result register, to o_valid.
// Synchronous active-low reset returns to hunting, max length 1024.
// o_stall rises only when both the input and result registers are full
// and the result side is stalled.
// ----------------------------------------------------------------------------
module serial_frame_receiver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_checksum_ok,
    output logic [15:0] o_frame_length,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [15:0] r_max_len;
    logic        r_out_valid;
    sfr_pkg::t_result r_out;

    logic             in_xfer;
    logic             advance;
    sfr_pkg::t_result res;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign in_xfer = i_valid && !o_stall;

    sfr_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_byte    (r_in_byte),
        .i_max_len (r_max_len),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= sfr_pkg::MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_xfer) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (advance && res.valid) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_kind  = r_out.kind;
    assign o_payload_byte = r_out.payload_byte;
    assign o_checksum_ok  = r_out.checksum_ok;
    assign o_frame_length = r_out.frame_length;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with room in the pipeline");

    a_payload_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_out.kind == sfr_pkg::KIND_PAYLOAD
        |-> o_frame_length == 16'd0 && !o_checksum_ok)
        else $error("payload result with frame fields set");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Randomized self-checking bench for serial_frame_receiver_top.
// Streams frames (start byte, big-endian length, payload, XOR checksum,
// trailer) with noise, bad checksums, over-length headers and cut-off
// frames. Sweeps the max-length register through its extremes, and applies
// random idles on the input and random stalls on the result side. A
// scoreboard tracks the frame state and checks every result transfer in
// order.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_PERIOD   = 10;
    localparam int IDLE_LIMIT   = 1000;
    localparam int PHASE_BYTES  = 64;
    localparam int DRAIN_CYCLES = 4;
    localparam int END_CYCLES   = 8;

    class frame_scoreboard;
        sfr_pkg::t_phase  phase;
        logic [15:0]      max_len;
        logic [15:0]      decl_len;
        logic [15:0]      remaining;
        logic [7:0]       xor_acc;
        logic             chk_match;
        sfr_pkg::t_result expected_q[$];
        int               errors;

        function new();
            phase     = sfr_pkg::PH_HUNT;
            max_len   = sfr_pkg::MAX_LEN_RESET;
            decl_len  = '0;
            remaining = '0;
            xor_acc   = '0;
            chk_match = 1'b0;
            errors    = 0;
        endfunction

        function void set_max_len(logic [15:0] value);
            max_len = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_byte(logic [7:0] b);
            sfr_pkg::t_result r;
            r = '0;
            r.valid = 1'b1;
            case (phase)
                sfr_pkg::PH_LEN_HI: begin
                    decl_len = {b, 8'h00};
                    xor_acc ^= b;
                    phase = sfr_pkg::PH_LEN_LO;
                end
                sfr_pkg::PH_LEN_LO: begin
                    decl_len[7:0] = b;
                    xor_acc ^= b;
                    if (decl_len > max_len) begin
                        phase = sfr_pkg::PH_HUNT;
                        r.kind = sfr_pkg::KIND_LEN_ERROR;
                        r.frame_length = decl_len;
                        expected_q.push_back(r);
                    end else begin
                        remaining = decl_len;
                        if (decl_len == 16'd0) begin
                            phase = sfr_pkg::PH_CHECKSUM;
                        end else begin
                            phase = sfr_pkg::PH_PAYLOAD;
                        end
                    end
                end
                sfr_pkg::PH_PAYLOAD: begin
                    xor_acc ^= b;
                    if (remaining > 16'd0) begin
                        remaining--;
                    end
                    if (remaining == 16'd0) begin
                        phase = sfr_pkg::PH_CHECKSUM;
                    end
                    r.kind = sfr_pkg::KIND_PAYLOAD;
                    r.payload_byte = b;
                    expected_q.push_back(r);
                end
                sfr_pkg::PH_CHECKSUM: begin
                    chk_match = (b == xor_acc);
                    phase = sfr_pkg::PH_TRAILER;
                end
                sfr_pkg::PH_TRAILER: begin
                    phase = sfr_pkg::PH_HUNT;
                    r.kind = sfr_pkg::KIND_FRAME_END;
                    r.checksum_ok = chk_match;
                    r.frame_length = decl_len;
                    expected_q.push_back(r);
                end
                default: begin
                    if (b == sfr_pkg::START_BYTE) begin
                        xor_acc   = '0;
                        decl_len  = '0;
                        remaining = '0;
                        chk_match = 1'b0;
                        phase     = sfr_pkg::PH_LEN_HI;
                    end else begin
                        phase = sfr_pkg::PH_HUNT;
                    end
                end
            endcase
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] data, logic ok,
                                   logic [15:0] len);
            sfr_pkg::t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: kind %0d byte %02h ok %0b length %0d",
                         $time, kind, data, ok, len);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: result_kind expected %0d, actual %0d",
                         $time, want.kind, kind);
                errors++;
            end
            if (data !== want.payload_byte) begin
                $display("%0t: payload_byte expected %02h, actual %02h",
                         $time, want.payload_byte, data);
                errors++;
            end
            if (ok !== want.checksum_ok) begin
                $display("%0t: checksum_ok expected %0b, actual %0b",
                         $time, want.checksum_ok, ok);
                errors++;
            end
            if (len !== want.frame_length) begin
                $display("%0t: frame_length expected %0d, actual %0d",
                         $time, want.frame_length, len);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_result_kind;
    logic [7:0]  o_payload_byte;
    logic        o_checksum_ok;
    logic [15:0] o_frame_length;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;

    frame_scoreboard rx_book = new();
    int          send_mode = 1;
    int          recv_mode = 1;
    int unsigned cur_max = 32'(sfr_pkg::MAX_LEN_RESET);

    serial_frame_receiver_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_payload_byte (o_payload_byte),
        .o_checksum_ok  (o_checksum_ok),
        .o_frame_length (o_frame_length),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    initial begin
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    // 0: no idling, 1: random idling before every transfer, 2: occasional
    function automatic int wait_cycles(input int mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 19);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
        endcase
    endfunction

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == sfr_pkg::START_BYTE) begin
            b = ~b;
        end
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = wait_cycles(send_mode);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_rx_byte = b;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        rx_book.note_byte(b);
    endtask

    task automatic drain(input int settle);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (rx_book.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_max(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_wr_data = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        rx_book.set_max_len(value);
        cur_max = 32'(value);
    endtask

    task automatic send_frame(output int sent);
        logic [7:0]  fb[$];
        logic [7:0]  acc;
        int unsigned len;
        int unsigned limit;
        int          n_cut;
        int          i;
        bit          too_long;
        repeat ($urandom_range(0, 3)) send_byte(noise_byte());
        too_long = (cur_max < 32'hFFFF) && ($urandom_range(0, 9) == 0);
        if (too_long) begin
            len = ($urandom_range(0, 1) == 0) ? cur_max + 1
                                              : $urandom_range(cur_max + 1, 32'hFFFF);
        end else begin
            limit = (cur_max < 12) ? cur_max : 12;
            len = ($urandom_range(0, 9) == 0 && cur_max <= 64) ? cur_max
                                                              : $urandom_range(0, limit);
        end
        fb.push_back(sfr_pkg::START_BYTE);
        fb.push_back(len[15:8]);
        fb.push_back(len[7:0]);
        acc = len[15:8] ^ len[7:0];
        if (!too_long) begin
            for (i = 0; i < int'(len); i++) begin
                fb.push_back(8'($urandom_range(0, 255)));
                acc ^= fb[$];
            end
            if ($urandom_range(0, 3) == 0) begin
                acc ^= 8'(1 << $urandom_range(0, 7));
            end
            fb.push_back(acc);
            fb.push_back(8'($urandom_range(0, 255)));
        end
        n_cut = fb.size();
        // cut-off frames only while lengths stay short
        if (!too_long && cur_max <= 64 && $urandom_range(0, 9) == 0) begin
            n_cut = $urandom_range(1, fb.size() - 1);
        end
        for (i = 0; i < n_cut; i++) begin
            send_byte(fb[i]);
        end
        sent = n_cut;
        if (too_long) begin
            repeat ($urandom_range(0, 4)) send_byte(noise_byte());
        end
    endtask

    initial begin : result_sink
        int hold;
        forever begin
            hold = wait_cycles(recv_mode);
            repeat (hold) begin
                @(negedge i_clk);
                i_stall = 1'b1;
            end
            @(negedge i_clk);
            i_stall = 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            rx_book.check_result(o_result_kind, o_payload_byte, o_checksum_ok,
                                 o_frame_length);
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_stall === 1'b0) ||
                (o_valid === 1'b1 && i_stall === 1'b0)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("** serial_frame_receiver_top: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [7:0]  directed[];
        int unsigned plan_max[6];
        int          phase_bytes;
        int          n;
        int          p;
        // noise; zero length; bad checksum; start byte as payload; length one over max
        directed = '{8'hFF, 8'h00, 8'h55,
                     8'h02, 8'h00, 8'h00, 8'h00, 8'hFF,
                     8'h02, 8'h00, 8'h01, 8'hAB, 8'h12, 8'h00,
                     8'h02, 8'h00, 8'h02, 8'h02, 8'hFF, 8'hFF, 8'h5A,
                     8'h02, 8'h04, 8'h01};
        plan_max = '{32'hFFFF, 0, 1, $urandom_range(2, 64), 1024,
                     $urandom_range(0, 32'hFFFF)};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k]) begin
            send_byte(directed[k]);
        end

        for (p = 0; p < 6; p++) begin
            drain(DRAIN_CYCLES);
            write_max(16'(plan_max[p]));
            send_mode = $urandom_range(0, 2);
            recv_mode = $urandom_range(0, 2);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                send_frame(n);
                phase_bytes += n;
            end
        end

        drain(END_CYCLES);
        if (rx_book.errors == 0) begin
            $display("** serial_frame_receiver_top: PASSED **");
        end else begin
            $display("** serial_frame_receiver_top: FAILED **");
        end
        $finish;
    end
endmodule
